// ===== src/fir_filter_100_tap_macros.svh =====
// assertion macros shared by the fir filter rtl
`ifndef FIR_FILTER_100_TAP_MACROS_SVH
`define FIR_FILTER_100_TAP_MACROS_SVH

`ifndef SYNTHESIS
// plain property, clocked on clk_i, off while in reset
`define FIR100_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// same-cycle implication
`define FIR100_ASSERT_IMPL(label, ante, cons, msg) \
  `FIR100_ASSERT(label, (ante) |-> (cons), msg)
// next-cycle implication
`define FIR100_ASSERT_NEXT(label, ante, cons, msg) \
  `FIR100_ASSERT(label, (ante) |=> (cons), msg)
`else
`define FIR100_ASSERT(label, prop, msg)
`define FIR100_ASSERT_IMPL(label, ante, cons, msg)
`define FIR100_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ===== src/fir100_pkg.sv =====
// constants, coefficient table and control types of the fir filter
`default_nettype none

package fir100_pkg;

  localparam int Taps       = 100;
  localparam int CoefBits   = 16;
  localparam int SampleBits = 10;
  localparam int OutBits    = 16;
  localparam int DesignTaps = 100;

  localparam int PtrBits  = (Taps > 1) ? $clog2(Taps) : 1;
  localparam int FillBits = $clog2(Taps + 1);
  localparam int ProdBits = SampleBits + 1 + CoefBits;
  localparam int AccBits  = ProdBits + PtrBits;
  localparam int ResBits  = AccBits + 1;

  localparam logic [OutBits-1:0] OffsetReset = OutBits'(5500);
  localparam logic [OutBits-1:0] OutMax      = '1;

  // design coefficients in units of 1/10000
  localparam longint DesignDiv  = 10000;
  localparam longint DesignHalf = DesignDiv / 2;

  typedef int design_tab_t [DesignTaps];
  localparam design_tab_t DesignCoef = '{
    -20, -20, -20, -19, -17, -15, -11, -6, 1, 10,
    20, 32, 46, 60, 74, 87, 98, 106, 110, 110,
    104, 92, 73, 48, 17, -19, -58, -101, -143, -185,
    -222, -254, -278, -293, -297, -289, -269, -237, -193, -140,
    -79, -12, 59, 129, 196, 258, 311, 352, 382, 396,
    396, 382, 352, 311, 258, 196, 129, 59, -12, -79,
    -140, -193, -237, -269, -289, -297, -293, -278, -254, -222,
    -185, -143, -101, -58, -19, 17, 48, 73, 92, 104,
    110, 110, 106, 98, 87, 74, 60, 46, 32, 20,
    10, 1, -6, -11, -15, -17, -19, -20, -20, -20
  };

  typedef logic signed [CoefBits-1:0] coef_rom_t [Taps];

  // scale to CoefBits-1 fraction bits, round half away from zero
  function automatic coef_rom_t build_coef_rom();
    coef_rom_t rom;
    longint    num;
    longint    mag;
    longint    q;
    for (int i = 0; i < Taps; i++) begin
      if (i < DesignTaps) begin
        num = longint'(DesignCoef[i]) * (longint'(1) << (CoefBits - 1));
        mag = (num < 0) ? -num : num;
        q   = (mag + DesignHalf) / DesignDiv;
        rom[i] = CoefBits'((num < 0) ? -q : q);
      end else begin
        rom[i] = '0;
      end
    end
    return rom;
  endfunction

  localparam coef_rom_t CoefRom = build_coef_rom();

  // controller to datapath
  typedef struct packed {
    logic load;    // take the sample, restart the tap walk
    logic issue;   // read one tap this cycle
    logic finish;  // move the result into the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_tap;
    logic pipe_busy;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ===== src/fir_filter_100_tap.sv =====
// top level of the 100-tap direct-form fir filter
`default_nettype none

// 100-tap direct-form fir filter over 10-bit unsigned converter samples.
// each input request carries one sample; it goes into a ring of the last 100
// samples (zeros after reset) and the block sums coefficient k times the k-th
// newest sample with a fixed q1.15 coefficient table, shifts the sum right by
// 15 (rounding toward minus infinity), adds the output_offset register (reset
// 5500) and clamps to 0..65535 for one output request. one shared multiplier
// walks the taps one per cycle: the result reaches the output register after
// 100 tap reads from the ring memory, the drain of the read/multiply/accumulate
// pipeline and the load of the output register. one item is worked on at a
// time; in_stall_o is high from accept until the result is in the output
// register, which then waits for the sink on its own while the next sample is
// taken. the offset is written through cfg_valid_i/cfg_data_i (cfg_ready_o is
// always high) and must only change while no item is in flight.

module fir_filter_100_tap
  import fir100_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // sample requests
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [SampleBits-1:0] sample_i,
  // filtered results
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [OutBits-1:0]         filtered_o,
  // offset register write
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [OutBits-1:0]    cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  fir100_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fir100_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (sample_i),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .filtered_o  (filtered_o)
  );

endmodule

`default_nettype wire

// ===== src/fir100_datapath.sv =====
// sample ring, coefficient table, multiply-accumulate and output register
`default_nettype none

`include "fir_filter_100_tap_macros.svh"

module fir100_datapath
  import fir100_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire cmd_t                  cmd_i,
  output sts_t                       sts_o,
  input  wire logic [SampleBits-1:0] sample_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [OutBits-1:0]    cfg_data_i,
  input  wire logic                  out_stall_i,
  output logic                       out_valid_o,
  output logic [OutBits-1:0]         filtered_o
);

  logic [SampleBits-1:0]      ring_q [Taps];
  logic [OutBits-1:0]         offset_q;
  logic [PtrBits-1:0]         wp_q;
  logic [FillBits-1:0]        fill_q;
  logic [PtrBits-1:0]         rd_idx_q;
  logic [PtrBits-1:0]         tap_q;
  logic [SampleBits-1:0]      rd_data_q;
  logic signed [CoefBits-1:0] coef_q;
  logic                       ent_ok_q;
  logic                       s1_vld_q;
  logic signed [ProdBits-1:0] prod_q;
  logic                       s2_vld_q;
  logic signed [AccBits-1:0]  acc_q;
  logic                       out_valid_q;
  logic [OutBits-1:0]         out_data_q;
  logic signed [AccBits-1:0]  shifted;
  logic signed [ResBits-1:0]  sum;
  logic [OutBits-1:0]         result_d;

  // offset register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= OffsetReset;
    end else if (cfg_we_i) begin
      offset_q <= cfg_data_i;
    end
  end

  // write pointer and fill count; slots at or above the fill count read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      fill_q <= '0;
    end else if (cmd_i.load) begin
      wp_q <= (wp_q == PtrBits'(Taps - 1)) ? '0 : wp_q + 1'b1;
      if (fill_q != FillBits'(Taps)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  // ring memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ring_q[wp_q] <= sample_i;
    end
    rd_data_q <= ring_q[rd_idx_q];
  end

  // tap walk, newest sample first
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rd_idx_q <= wp_q;
      tap_q    <= '0;
    end else if (cmd_i.issue) begin
      rd_idx_q <= (rd_idx_q == '0) ? PtrBits'(Taps - 1) : rd_idx_q - 1'b1;
      tap_q    <= tap_q + 1'b1;
    end
    coef_q   <= CoefRom[tap_q];
    ent_ok_q <= FillBits'(rd_idx_q) < fill_q;
    prod_q   <= ent_ok_q ? ProdBits'($signed({1'b0, rd_data_q}) * coef_q) : '0;
    if (cmd_i.load) begin
      acc_q <= '0;
    end else if (s2_vld_q) begin
      acc_q <= acc_q + AccBits'(prod_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= cmd_i.issue;
      s2_vld_q <= s1_vld_q;
    end
  end

  // floor shift, offset, clamp
  always_comb begin
    shifted = acc_q >>> (CoefBits - 1);
    sum     = ResBits'(shifted) + $signed(ResBits'({1'b0, offset_q}));
    if (sum < 0) begin
      result_d = '0;
    end else if (sum > $signed(ResBits'({1'b0, OutMax}))) begin
      result_d = OutMax;
    end else begin
      result_d = sum[OutBits-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_data_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_data_q;

  assign sts_o.last_tap  = tap_q == PtrBits'(Taps - 1);
  assign sts_o.pipe_busy = s1_vld_q | s2_vld_q;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  `FIR100_ASSERT(a_fill_bound, fill_q <= FillBits'(Taps), "fill count past ring depth")

endmodule

`default_nettype wire

// ===== src/fir100_ctrl.sv =====
// sequencer for accept, tap walk, pipeline drain and result hand-off
`default_nettype none

`include "fir_filter_100_tap_macros.svh"

module fir100_ctrl
  import fir100_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StRun   = 2'd1;
  localparam logic [1:0] StDrain = 2'd2;
  localparam logic [1:0] StDone  = 2'd3;

  logic [1:0] state_q;
  logic [1:0] state_d;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i) state_d = StRun;
      StRun:   if (sts_i.last_tap) state_d = StDrain;
      StDrain: if (!sts_i.pipe_busy) state_d = StDone;
      StDone:  if (sts_i.out_free) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o   = state_q != StIdle;
  assign cmd_o.load   = (state_q == StIdle) && in_valid_i;
  assign cmd_o.issue  = state_q == StRun;
  assign cmd_o.finish = (state_q == StDone) && sts_i.out_free;

  `FIR100_ASSERT_IMPL(a_done_drained, state_q == StDone, !sts_i.pipe_busy,
                      "result taken before the pipeline drained")
  `FIR100_ASSERT_NEXT(a_walk_starts, cmd_o.load, cmd_o.issue,
                      "tap walk did not start after a request")
  `FIR100_ASSERT_NEXT(a_finish_once, cmd_o.finish, !cmd_o.finish && !cmd_o.issue,
                      "result handed off twice")

endmodule

`default_nettype wire

// ===== bench/fir100_response_checker.sv =====
// filter response checker: watches the channels, predicts each output and compares
module fir100_response_checker
  import fir100_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [SampleBits-1:0] sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [OutBits-1:0]    filtered_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [OutBits-1:0]    cfg_data_i,
  output int                    failures_o,
  output int                    pending_o
);

  localparam logic [OutBits-1:0] OffsetAtReset = 16'd5500;
  localparam int                 WeightScale   = 10000;

  // tap weights in units of 1/10000
  localparam int TapWeight [100] = '{
    -20, -20, -20, -19, -17, -15, -11, -6, 1, 10,
    20, 32, 46, 60, 74, 87, 98, 106, 110, 110,
    104, 92, 73, 48, 17, -19, -58, -101, -143, -185,
    -222, -254, -278, -293, -297, -289, -269, -237, -193, -140,
    -79, -12, 59, 129, 196, 258, 311, 352, 382, 396,
    396, 382, 352, 311, 258, 196, 129, 59, -12, -79,
    -140, -193, -237, -269, -289, -297, -293, -278, -254, -222,
    -185, -143, -101, -58, -19, 17, 48, 73, 92, 104,
    110, 110, 106, 98, 87, 74, 60, 46, 32, 20,
    10, 1, -6, -11, -15, -17, -19, -20, -20, -20
  };

  longint                tap_coef [Taps];
  logic [SampleBits-1:0] history [Taps];
  int                    newest_slot;
  logic [OutBits-1:0]    offset;
  logic [OutBits-1:0]    filtered_due [$];

  // q1.15 weights, rounded half away from zero, zero past the designed taps
  initial begin
    longint num;
    longint mag;
    for (int i = 0; i < Taps; i++) begin
      if (i < 100) begin
        num = longint'(TapWeight[i]) * (longint'(1) << (CoefBits - 1));
        mag = (num < 0) ? -num : num;
        mag = (mag + WeightScale / 2) / WeightScale;
        tap_coef[i] = (num < 0) ? -mag : mag;
      end else begin
        tap_coef[i] = 0;
      end
    end
  end

  // convolution over the history, newest sample at slot
  function automatic logic [OutBits-1:0] filter_response(int slot);
    longint acc;
    longint val;
    int     idx;
    acc = 0;
    idx = slot;
    for (int i = 0; i < Taps; i++) begin
      acc += tap_coef[i] * longint'(history[idx]);
      idx = (idx == 0) ? Taps - 1 : idx - 1;
    end
    val = (acc >>> (CoefBits - 1)) + longint'(offset);
    if (val < 0) val = 0;
    if (val > 65535) val = 65535;
    return OutBits'(val);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [OutBits-1:0] want;
    if (!rst_ni) begin
      for (int i = 0; i < Taps; i++) history[i] = '0;
      newest_slot = 0;
      offset = OffsetAtReset;
      filtered_due.delete();
      failures_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) offset = cfg_data_i;
      // results first: a request taken this edge cannot answer itself
      if (out_valid_i && !out_stall_i) begin
        if (filtered_due.size() == 0) begin
          $error("filtered result %0d with no request waiting", filtered_i);
          failures_o++;
        end else begin
          want = filtered_due.pop_front();
          if (filtered_i !== want) begin
            $error("filtered mismatch: expected %0d, actual %0d", want, filtered_i);
            failures_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        history[newest_slot] = sample_i;
        filtered_due.push_back(filter_response(newest_slot));
        newest_slot = (newest_slot == Taps - 1) ? 0 : newest_slot + 1;
      end
      pending_o = filtered_due.size();
    end
  end

endmodule

// ===== bench/tb_fir_filter_100_tap.sv =====
// stimulus, watchdog and verdict for the 100-tap fir filter
module tb_fir_filter_100_tap;
  import fir100_pkg::*;

  // no-progress limit: covers the long output hold-off plus a full tap walk
  localparam int StallLimit = 5000;
  localparam int HoldCycles = 400;
  localparam int PhaseItems = 120;

  // directed opening: rails, single bits, alternating patterns, short bursts
  localparam logic [SampleBits-1:0] OpeningSeq [20] = '{
    10'd1023, 10'd0, 10'd0, 10'd1, 10'd512, 10'd511, 10'd1023, 10'd1023,
    10'd1023, 10'd1023, 10'd0, 10'd0, 10'd682, 10'd341, 10'd1023, 10'd0,
    10'd2, 10'd256, 10'd1022, 10'd0
  };

  // shapes of the random sample stream
  typedef enum int {PatNoise, PatRails, PatLevel, PatSquare} pattern_e;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [SampleBits-1:0] sample_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [OutBits-1:0]    filtered_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [OutBits-1:0]    cfg_data_i;

  int failures;
  int pending;
  int send_idle_pct;
  int recv_stall_pct;
  int hold_asked;
  int hold_served;
  int hold_left;
  int quiet_cycles;

  fir_filter_100_tap dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  fir100_response_checker checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .sample_i    (sample_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_i  (filtered_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .failures_o  (failures),
    .pending_o   (pending)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // watchdog: cycles without any handshake on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("tb_fir_filter_100_tap: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // output side: random stall, or a long hold-off when the stimulus asks for one
  initial begin
    out_stall_i = 1'b0;
    hold_served = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_served != hold_asked) begin
        hold_served = hold_asked;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // offer one sample request, return at the falling edge after it is taken;
  // valid stays high so a following request needs no second assignment
  task automatic send_sample(input logic [SampleBits-1:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      sample_i <= SampleBits'($urandom_range(1023));
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    sample_i <= s;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
    @(negedge clk_i);
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic drain_filter();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
  endtask

  task automatic write_offset(input logic [OutBits-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    pattern_e              pattern;
    int                    run_left;
    int                    half_period;
    logic [SampleBits-1:0] level;
    logic [SampleBits-1:0] s;
    logic [OutBits-1:0]    offset;

    in_valid_i = 1'b0;
    sample_i = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_asked = 0;
    quiet_cycles = 0;
    run_left = 0;
    pattern = PatNoise;
    half_period = 1;
    level = '0;
    rst_ni = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part at the reset offset, no idling on either side
    foreach (OpeningSeq[i]) send_sample(OpeningSeq[i]);

    // random phases: each one changes the offset while idle, then streams samples
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          offset = '0;              // negative sums clamp at zero
        end
        1: begin
          send_idle_pct = 68;
          recv_stall_pct = 0;
          offset = OutMax;          // positive sums clamp at full scale
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 68;
          offset = OutBits'($urandom);
        end
        default: begin
          send_idle_pct = 8;
          recv_stall_pct = 8;
          offset = OutBits'($urandom_range(3000, 20000));
        end
      endcase
      drain_filter();
      write_offset(offset);

      for (int n = 0; n < PhaseItems; n++) begin
        // hold the output side off so the filter backs up into its input
        if (ph == 2 && n == 10) hold_asked++;
        // sender pauses until the filter is empty
        if (ph == 3 && n == 60) drain_filter();

        // pick a new stream shape when the current run is used up
        if (run_left == 0) begin
          pattern = pattern_e'($urandom_range(3));
          run_left = $urandom_range(1, 80);
          level = SampleBits'($urandom_range(1023));
          half_period = $urandom_range(1, 50);
        end
        case (pattern)
          PatNoise:  s = SampleBits'($urandom_range(1023));
          PatRails:  s = $urandom_range(1) ? 10'd1023 : 10'd0;
          PatLevel:  s = level;
          default:   s = ((run_left / half_period) % 2 != 0) ? 10'd1023 : 10'd0;
        endcase
        run_left--;
        send_sample(s);
      end
    end

    // let the last results drain, then idle before the verdict
    drain_filter();
    repeat (150) @(negedge clk_i);
    if (failures == 0) begin
      $display("tb_fir_filter_100_tap: PASS");
    end else begin
      $display("tb_fir_filter_100_tap: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/fir100_pkg.sv
src/fir100_datapath.sv
src/fir100_ctrl.sv
src/fir_filter_100_tap.sv
bench/fir100_response_checker.sv
bench/tb_fir_filter_100_tap.sv
